/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the bracket nesting checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BNC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BNC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/bnc_pkg.sv */
// Types, constants and helper functions of the bracket nesting checker.
`timescale 1ns / 1ps

package bnc_pkg;

    localparam int MAX_DEPTH_DEF = 128;
    localparam int SCORE_W       = 64;
    localparam int CORRUPT_W     = 15;
    localparam int KIND_W        = 2;

    localparam logic [7:0] CH_OPEN_ROUND  = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE = 8'h5B;
    localparam logic [7:0] CH_OPEN_CURLY  = 8'h7B;
    localparam logic [7:0] CH_OPEN_ANGLE  = 8'h3C;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

    localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd3;

    typedef enum logic [1:0] {
        ST_BALANCED   = 2'd0,
        ST_CORRUPT    = 2'd1,
        ST_INCOMPLETE = 2'd2,
        ST_OVERFLOW   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REFILL,
        S_WALK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              is_open;
        logic              is_close;
        logic [KIND_W-1:0] kind;
    } t_sym_class;

    typedef struct packed {
        logic clear;
        logic step;
    } t_acc_ctrl;

    function automatic t_sym_class classify(input logic [7:0] sym);
        t_sym_class c;
        c = '0;
        case (sym)
            CH_OPEN_ROUND: begin
                c.is_open = 1'b1;
                c.kind    = KIND_ROUND;
            end
            CH_OPEN_SQUARE: begin
                c.is_open = 1'b1;
                c.kind    = KIND_SQUARE;
            end
            CH_OPEN_CURLY: begin
                c.is_open = 1'b1;
                c.kind    = KIND_CURLY;
            end
            CH_OPEN_ANGLE: begin
                c.is_open = 1'b1;
                c.kind    = KIND_ANGLE;
            end
            CH_CLOSE_ROUND: begin
                c.is_close = 1'b1;
                c.kind     = KIND_ROUND;
            end
            CH_CLOSE_SQUARE: begin
                c.is_close = 1'b1;
                c.kind     = KIND_SQUARE;
            end
            CH_CLOSE_CURLY: begin
                c.is_close = 1'b1;
                c.kind     = KIND_CURLY;
            end
            CH_CLOSE_ANGLE: begin
                c.is_close = 1'b1;
                c.kind     = KIND_ANGLE;
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

    function automatic logic [CORRUPT_W-1:0] close_score(input logic [KIND_W-1:0] kind);
        logic [CORRUPT_W-1:0] s;
        case (kind)
            KIND_ROUND:  s = 15'd3;
            KIND_SQUARE: s = 15'd57;
            KIND_CURLY:  s = 15'd1197;
            KIND_ANGLE:  s = 15'd25137;
            default:     s = '0;
        endcase
        return s;
    endfunction

endpackage

/* rtl/bnc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module bnc_ram #(
    parameter int WIDTH = bnc_pkg::KIND_W,
    parameter int DEPTH = bnc_pkg::MAX_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/bnc_score_acc.sv */
// Completion score accumulator: score times five plus bracket kind plus one, one entry a cycle while step is set.
`timescale 1ns / 1ps

module bnc_score_acc (
    input  logic                              i_clk,
    input  bnc_pkg::t_acc_ctrl                i_ctrl,
    input  logic [bnc_pkg::KIND_W-1:0]        i_kind,
    output logic [bnc_pkg::SCORE_W-1:0]       o_score
);

    logic [bnc_pkg::SCORE_W-1:0] r_score;
    logic [bnc_pkg::SCORE_W-1:0] n_score;

    always_comb begin
        n_score = r_score;
        if (i_ctrl.clear) begin
            n_score = '0;
        end else if (i_ctrl.step) begin
            n_score = (r_score << 2) + r_score + bnc_pkg::SCORE_W'(i_kind)
                      + bnc_pkg::SCORE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_score <= n_score;
    end

    assign o_score = r_score;

endmodule

/* rtl/bracket_nesting_checker.sv */
// Bracket nesting checker top level: character decode, stack control and result register.
// A mid-line character is taken in the idle state; a pop that leaves the stack non-empty then
// passes through the refill state, as the new top of stack is read back from the stack memory.
// A line end goes to the emit state, through the walk state first for an incomplete line, where the
// completion walk reads one stack entry a cycle. Characters are accepted only in the idle state.
// Results wait in an output register. Reset is synchronous and active low; the stack memory is not cleared.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bracket_nesting_checker #(
    parameter int MAX_DEPTH = bnc_pkg::MAX_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_symbol,
    input  logic                          i_line_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [bnc_pkg::CORRUPT_W-1:0] o_corrupt_score,
    output logic [bnc_pkg::SCORE_W-1:0]   o_completion_score
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int AW      = $clog2(MAX_DEPTH);

    bnc_pkg::t_state                r_state, n_state;
    logic [DEPTH_W-1:0]             r_depth, n_depth;
    logic                           r_failed, n_failed;
    bnc_pkg::t_status               r_code, n_code;
    logic [bnc_pkg::CORRUPT_W-1:0]  r_err_score, n_err_score;
    logic [bnc_pkg::KIND_W-1:0]     r_top, n_top;
    logic [DEPTH_W-1:0]             r_walk_cnt, n_walk_cnt;
    logic                           r_walk_pend, n_walk_pend;
    logic                           r_out_valid;
    bnc_pkg::t_status               r_out_status;
    logic [bnc_pkg::CORRUPT_W-1:0]  r_out_corrupt;
    logic [bnc_pkg::SCORE_W-1:0]    r_out_completion;

    bnc_pkg::t_sym_class            cls;
    bnc_pkg::t_acc_ctrl             acc_ctrl;
    logic [bnc_pkg::SCORE_W-1:0]    acc_score;
    logic [bnc_pkg::KIND_W-1:0]     rd_data;
    logic [AW-1:0]                  rd_addr;
    logic [DEPTH_W-1:0]             below_top;
    logic [DEPTH_W-1:0]             walk_next;
    logic                           in_fire;
    logic                           live;
    logic                           top_match;
    logic                           has_room;
    logic                           do_push;
    logic                           do_pop;
    logic                           do_ovf;
    logic                           do_bad;
    logic                           out_free;
    logic                           emit_fire;

    assign cls       = bnc_pkg::classify(i_symbol);
    assign in_fire   = i_in_valid && o_in_ready;
    assign live      = in_fire && !r_failed;
    assign has_room  = r_depth < DEPTH_W'(MAX_DEPTH);
    assign top_match = cls.is_close && (r_depth != '0) && (r_top == cls.kind);
    assign do_push   = live && cls.is_open && has_room;
    assign do_ovf    = live && cls.is_open && !has_room;
    assign do_pop    = live && !cls.is_open && top_match;
    assign do_bad    = live && !cls.is_open && !top_match;
    assign out_free  = !r_out_valid || i_out_ready;
    assign emit_fire = (r_state == bnc_pkg::S_EMIT) && out_free;
    assign below_top = r_depth - DEPTH_W'(2);
    assign walk_next = r_walk_cnt - DEPTH_W'(1);

    // The cached top of stack is refreshed from memory in its own state after a pop,
    // so a read never meets a write to the same entry.
    always_comb begin
        n_depth     = r_depth;
        n_failed    = r_failed;
        n_code      = r_code;
        n_err_score = r_err_score;
        n_top       = r_top;
        n_walk_cnt  = r_walk_cnt;
        n_walk_pend = 1'b0;
        if (do_push) begin
            n_depth = r_depth + DEPTH_W'(1);
            n_top   = cls.kind;
        end
        if (do_pop) begin
            n_depth = r_depth - DEPTH_W'(1);
        end
        if (do_ovf) begin
            n_failed    = 1'b1;
            n_code      = bnc_pkg::ST_OVERFLOW;
            n_err_score = '0;
        end
        if (do_bad) begin
            n_failed    = 1'b1;
            n_code      = bnc_pkg::ST_CORRUPT;
            n_err_score = cls.is_close ? bnc_pkg::close_score(cls.kind) : '0;
        end
        if (in_fire && i_line_end) begin
            n_walk_cnt = n_depth;
        end
        if (r_state == bnc_pkg::S_REFILL) begin
            n_top = rd_data;
        end
        if (r_state == bnc_pkg::S_WALK && r_walk_cnt != '0) begin
            n_walk_cnt  = walk_next;
            n_walk_pend = 1'b1;
        end
        if (emit_fire) begin
            n_depth     = '0;
            n_failed    = 1'b0;
            n_code      = bnc_pkg::ST_BALANCED;
            n_err_score = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bnc_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (i_line_end) begin
                        if (n_failed || n_depth == '0) begin
                            n_state = bnc_pkg::S_EMIT;
                        end else begin
                            n_state = bnc_pkg::S_WALK;
                        end
                    end else if (do_pop && n_depth != '0) begin
                        n_state = bnc_pkg::S_REFILL;
                    end
                end
            end
            bnc_pkg::S_REFILL: begin
                n_state = bnc_pkg::S_IDLE;
            end
            bnc_pkg::S_WALK: begin
                if (r_walk_cnt == '0 && r_walk_pend) begin
                    n_state = bnc_pkg::S_EMIT;
                end
            end
            bnc_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = bnc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bnc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == bnc_pkg::S_IDLE);
        acc_ctrl.clear = in_fire && i_line_end;
        acc_ctrl.step  = (r_state == bnc_pkg::S_WALK) && r_walk_pend;
        rd_addr        = (r_state == bnc_pkg::S_WALK) ? walk_next[AW-1:0]
                                                      : below_top[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bnc_pkg::S_IDLE;
            r_depth     <= '0;
            r_failed    <= 1'b0;
            r_code      <= bnc_pkg::ST_BALANCED;
            r_err_score <= '0;
            r_walk_cnt  <= '0;
            r_walk_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_failed    <= n_failed;
            r_code      <= n_code;
            r_err_score <= n_err_score;
            r_walk_cnt  <= n_walk_cnt;
            r_walk_pend <= n_walk_pend;
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (emit_fire) begin
            if (r_failed) begin
                r_out_status <= r_code;
            end else if (r_depth == '0) begin
                r_out_status <= bnc_pkg::ST_BALANCED;
            end else begin
                r_out_status <= bnc_pkg::ST_INCOMPLETE;
            end
            r_out_corrupt    <= (r_failed && r_code == bnc_pkg::ST_CORRUPT) ? r_err_score
                                                                            : '0;
            r_out_completion <= (!r_failed && r_depth != '0) ? acc_score : '0;
        end
    end

    bnc_ram #(
        .WIDTH (bnc_pkg::KIND_W),
        .DEPTH (MAX_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (do_push),
        .i_wr_addr (r_depth[AW-1:0]),
        .i_wr_data (cls.kind),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bnc_score_acc u_acc (
        .i_clk   (i_clk),
        .i_ctrl  (acc_ctrl),
        .i_kind  (rd_data),
        .o_score (acc_score)
    );

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_corrupt_score    = r_out_corrupt;
    assign o_completion_score = r_out_completion;

    `BNC_ASSERT_SAME(a_depth_bound, i_clk, i_rst_n, 1'b1, r_depth <= DEPTH_W'(MAX_DEPTH))
    `BNC_ASSERT_SAME(a_walk_in_stack, i_clk, i_rst_n, r_state == bnc_pkg::S_WALK, r_walk_cnt <= r_depth)
    `BNC_ASSERT_SAME(a_refill_nonempty, i_clk, i_rst_n, r_state == bnc_pkg::S_REFILL, r_depth != '0)
    `BNC_ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, emit_fire, o_out_valid && r_depth == '0)

endmodule

/* tb/tb_bracket_nesting_checker.sv */
// Self-checking testbench for the bracket nesting checker: directed table, random lines, scoreboard.
`timescale 1ns / 1ps

module tb_bracket_nesting_checker;
    import bnc_pkg::*;

    localparam int DEPTH       = MAX_DEPTH_DEF;
    localparam int ITEM_TARGET = 1850;
    localparam int N_DIRECTED  = 24;

    localparam logic [CORRUPT_W-1:0] PENALTY [4] = '{15'd3, 15'd57, 15'd1197, 15'd25137};

    typedef struct packed {
        t_status              status;
        logic [CORRUPT_W-1:0] corrupt;
        logic [SCORE_W-1:0]   completion;
    } t_line_result;

    typedef struct packed {
        logic [7:0]   symbol;
        logic         last;
        logic         typed;
        t_line_result result;
    } t_directed_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [7:0]           i_symbol;
    logic                 i_line_end;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [1:0]           o_status;
    logic [CORRUPT_W-1:0] o_corrupt_score;
    logic [SCORE_W-1:0]   o_completion_score;

    logic [KIND_W-1:0]    kind_stack [DEPTH];
    int                   nest_depth;
    logic                 line_broken;
    t_status              broken_status;
    logic [CORRUPT_W-1:0] broken_score;

    t_line_result         pending_results [$];
    logic [7:0]           line_chars [$];
    t_directed_row        directed_rows [N_DIRECTED];
    int                   mismatch_count;
    int                   live_items;
    bit                   send_burst;
    bit                   recv_burst;

    bracket_nesting_checker #(
        .MAX_DEPTH(DEPTH)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_symbol           (i_symbol),
        .i_line_end         (i_line_end),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_corrupt_score    (o_corrupt_score),
        .o_completion_score (o_completion_score)
    );

    always #6 i_clk = ~i_clk;

    function automatic int open_kind_of(input logic [7:0] c);
        case (c)
            CH_OPEN_ROUND:  return int'(KIND_ROUND);
            CH_OPEN_SQUARE: return int'(KIND_SQUARE);
            CH_OPEN_CURLY:  return int'(KIND_CURLY);
            CH_OPEN_ANGLE:  return int'(KIND_ANGLE);
            default:        return -1;
        endcase
    endfunction

    function automatic int close_kind_of(input logic [7:0] c);
        case (c)
            CH_CLOSE_ROUND:  return int'(KIND_ROUND);
            CH_CLOSE_SQUARE: return int'(KIND_SQUARE);
            CH_CLOSE_CURLY:  return int'(KIND_CURLY);
            CH_CLOSE_ANGLE:  return int'(KIND_ANGLE);
            default:         return -1;
        endcase
    endfunction

    function automatic logic [7:0] opener_of(input logic [KIND_W-1:0] k);
        case (k)
            KIND_ROUND:  return CH_OPEN_ROUND;
            KIND_SQUARE: return CH_OPEN_SQUARE;
            KIND_CURLY:  return CH_OPEN_CURLY;
            default:     return CH_OPEN_ANGLE;
        endcase
    endfunction

    function automatic logic [7:0] closer_of(input logic [KIND_W-1:0] k);
        case (k)
            KIND_ROUND:  return CH_CLOSE_ROUND;
            KIND_SQUARE: return CH_CLOSE_SQUARE;
            KIND_CURLY:  return CH_CLOSE_CURLY;
            default:     return CH_CLOSE_ANGLE;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] rand_kind();
        return KIND_W'($urandom_range(0, 3));
    endfunction

    // Half of these are brackets, the rest any byte at all.
    function automatic logic [7:0] any_symbol();
        if ($urandom_range(0, 1) == 1)
            return ($urandom_range(0, 1) == 1) ? opener_of(rand_kind()) : closer_of(rand_kind());
        return 8'($urandom_range(0, 255));
    endfunction

    // Steps the nesting state by one character and returns 1 when the line ends.
    function automatic bit nest_model_step(input logic [7:0] sym, input logic last,
                                           output t_line_result res, output bit live);
        int                 ok;
        int                 ck;
        logic [SCORE_W-1:0] score;
        live = !line_broken;
        res  = '0;
        ok   = open_kind_of(sym);
        ck   = close_kind_of(sym);
        if (!line_broken) begin
            if (ok >= 0) begin
                if (nest_depth < DEPTH) begin
                    kind_stack[nest_depth] = ok[KIND_W-1:0];
                    nest_depth++;
                end else begin
                    line_broken   = 1'b1;
                    broken_status = ST_OVERFLOW;
                    broken_score  = '0;
                end
            end else if (ck >= 0 && nest_depth > 0 &&
                         kind_stack[nest_depth-1] == ck[KIND_W-1:0]) begin
                nest_depth--;
            end else begin
                line_broken   = 1'b1;
                broken_status = ST_CORRUPT;
                broken_score  = (ck >= 0) ? PENALTY[ck] : '0;
            end
        end
        if (!last)
            return 1'b0;
        if (line_broken) begin
            res.status  = broken_status;
            res.corrupt = (broken_status == ST_CORRUPT) ? broken_score : '0;
        end else if (nest_depth == 0) begin
            res.status = ST_BALANCED;
        end else begin
            score = '0;
            for (int i = nest_depth - 1; i >= 0; i--)
                score = score * 64'd5 + 64'(kind_stack[i]) + 64'd1;
            res.status     = ST_INCOMPLETE;
            res.completion = score;
        end
        nest_depth    = 0;
        line_broken   = 1'b0;
        broken_status = ST_BALANCED;
        broken_score  = '0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Entered and left just after a falling edge.
    task automatic drive_symbol(input logic [7:0] sym, input logic last,
                                input logic typed, input t_line_result typed_res);
        int unsigned  gap;
        t_line_result res;
        bit           live;
        gap = send_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_symbol   <= sym;
        i_line_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
        if (nest_model_step(sym, last, res, live))
            pending_results = {pending_results, (typed ? typed_res : res)};
        if (live)
            live_items++;
        @(negedge i_clk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_chars.size(); i++)
            drive_symbol(line_chars[i], i == line_chars.size() - 1, 1'b0, '0);
        line_chars.delete();
    endtask

    task automatic build_nested(input int pairs, input bit keep_open);
        logic [KIND_W-1:0] opened [$];
        logic [KIND_W-1:0] k;
        int                opens_left;
        opens_left = pairs;
        while (opens_left > 0 || opened.size() > 0) begin
            if (opens_left > 0 && (opened.size() == 0 || $urandom_range(0, 1) == 1)) begin
                k = rand_kind();
                opened     = {opened, k};
                line_chars = {line_chars, opener_of(k)};
                opens_left--;
            end else if (keep_open && opens_left == 0 && $urandom_range(0, 2) == 0) begin
                break;
            end else begin
                line_chars = {line_chars, closer_of(opened.pop_back())};
            end
        end
    endtask

    task automatic build_random_line();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            build_nested($urandom_range(1, 12), 1'b0);
        end else if (pick < 60) begin
            build_nested($urandom_range(1, 12), 1'b1);
        end else if (pick < 66) begin
            repeat ($urandom_range(1, 40)) line_chars = {line_chars, opener_of(rand_kind())};
        end else if (pick < 90) begin
            build_nested($urandom_range(0, 8), 1'b1);
            if ($urandom_range(0, 1) == 1)
                line_chars = {line_chars, closer_of(rand_kind())};
            else
                line_chars = {line_chars, 8'($urandom_range(0, 255))};
            repeat ($urandom_range(0, 4)) line_chars = {line_chars, any_symbol()};
        end else begin
            repeat ($urandom_range(1, 8)) line_chars = {line_chars, any_symbol()};
        end
    endtask

    // Full-depth lines: left open, pushed past the limit, or closed again.
    task automatic build_deep_line(input int mode);
        logic [KIND_W-1:0] opened [$];
        repeat (DEPTH) begin
            opened     = {opened, rand_kind()};
            line_chars = {line_chars, opener_of(opened[$])};
        end
        if (mode == 1) begin
            repeat ($urandom_range(1, 3)) line_chars = {line_chars, opener_of(rand_kind())};
            repeat ($urandom_range(0, 3)) line_chars = {line_chars, any_symbol()};
        end else if (mode == 2) begin
            while (opened.size() > 0)
                line_chars = {line_chars, closer_of(opened.pop_back())};
        end
    endtask

    initial begin : stimulus
        int line_no;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_symbol       = '0;
        i_line_end     = 1'b0;
        i_out_ready    = 1'b0;
        mismatch_count = 0;
        live_items     = 0;
        send_burst     = 1'b0;
        recv_burst     = 1'b0;
        nest_depth     = 0;
        line_broken    = 1'b0;
        broken_status  = ST_BALANCED;
        broken_score   = '0;
        directed_rows  = '{
            '{CH_CLOSE_ROUND,  1'b1, 1'b1, '{ST_CORRUPT,    15'd3,     64'd0}},
            '{CH_CLOSE_SQUARE, 1'b1, 1'b1, '{ST_CORRUPT,    15'd57,    64'd0}},
            '{CH_CLOSE_CURLY,  1'b1, 1'b1, '{ST_CORRUPT,    15'd1197,  64'd0}},
            '{CH_CLOSE_ANGLE,  1'b1, 1'b1, '{ST_CORRUPT,    15'd25137, 64'd0}},
            '{8'h00,           1'b1, 1'b1, '{ST_CORRUPT,    15'd0,     64'd0}},
            '{8'hFF,           1'b1, 1'b1, '{ST_CORRUPT,    15'd0,     64'd0}},
            '{CH_OPEN_ROUND,   1'b0, 1'b0, '{ST_BALANCED,   15'd0,     64'd0}},
            '{CH_CLOSE_ROUND,  1'b1, 1'b1, '{ST_BALANCED,   15'd0,     64'd0}},
            '{CH_OPEN_ANGLE,   1'b1, 1'b1, '{ST_INCOMPLETE, 15'd0,     64'd4}},
            '{CH_OPEN_SQUARE,  1'b0, 1'b0, '{ST_BALANCED,   15'd0,     64'd0}},
            '{CH_OPEN_CURLY,   1'b0, 1'b0, '{ST_BALANCED,   15'd0,     64'd0}},
            '{CH_OPEN_ANGLE,   1'b0, 1'b0, '{ST_BALANCED,   15'd0,     64'd0}},
            '{CH_OPEN_ROUND,   1'b1, 1'b1, '{ST_INCOMPLETE, 15'd0,     64'd242}},
            '{CH_OPEN_CURLY,   1'b0, 1'b0, '{ST_BALANCED,   15'd0,     64'd0}},
            '{CH_CLOSE_SQUARE, 1'b0, 1'b0, '{ST_BALANCED,   15'd0,     64'd0}},
            '{CH_OPEN_ROUND,   1'b1, 1'b1, '{ST_CORRUPT,    15'd57,    64'd0}},
            '{CH_OPEN_SQUARE,  1'b0, 1'b0, '{ST_BALANCED,   15'd0,     64'd0}},
            '{CH_CLOSE_SQUARE, 1'b0, 1'b0, '{ST_BALANCED,   15'd0,     64'd0}},
            '{8'h61,           1'b0, 1'b0, '{ST_BALANCED,   15'd0,     64'd0}},
            '{CH_CLOSE_ANGLE,  1'b1, 1'b1, '{ST_CORRUPT,    15'd0,     64'd0}},
            '{CH_OPEN_ROUND,   1'b0, 1'b0, '{ST_BALANCED,   15'd0,     64'd0}},
            '{CH_OPEN_SQUARE,  1'b0, 1'b0, '{ST_BALANCED,   15'd0,     64'd0}},
            '{CH_CLOSE_SQUARE, 1'b0, 1'b0, '{ST_BALANCED,   15'd0,     64'd0}},
            '{CH_OPEN_ROUND,   1'b1, 1'b0, '{ST_BALANCED,   15'd0,     64'd0}}
        };
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[r])
            drive_symbol(directed_rows[r].symbol, directed_rows[r].last,
                         directed_rows[r].typed, directed_rows[r].result);
        line_no = 0;
        while (live_items < ITEM_TARGET) begin
            send_burst = ($urandom_range(0, 7) == 0);
            if (line_no % 40 == 20)
                build_deep_line((line_no / 40) % 3);
            else
                build_random_line();
            send_line();
            line_no++;
        end
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DEPTH + 20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("bracket_nesting_checker verification clean");
        else
            $display("bracket_nesting_checker verification failed");
        $finish;
    end

    initial begin : result_check
        int unsigned  stall;
        int           taken;
        t_line_result want;
        taken = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (taken % 8 == 0)
                recv_burst = ($urandom_range(0, 2) == 0);
            stall = recv_burst ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
            if (pending_results.size() == 0) begin
                flag_mismatch("result transfer with no line end outstanding");
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d", o_status, want.status));
                if (o_corrupt_score !== want.corrupt)
                    flag_mismatch($sformatf("corruption score %0d, expected %0d",
                                            o_corrupt_score, want.corrupt));
                if (o_completion_score !== want.completion)
                    flag_mismatch($sformatf("completion score %0d, expected %0d",
                                            o_completion_score, want.completion));
            end
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("bracket_nesting_checker verification failed");
        $finish;
    end

endmodule
